/* hdl/ptts_pkg.sv */
package ptts_pkg;

	localparam int SLOTS = 4;

	localparam logic [2:0] REG_POLICY = 3'd0;
	localparam logic [2:0] REG_TASKS  = 3'd1;
	localparam logic [2:0] REG_RUNLEN = 3'd2;
	localparam logic [2:0] REG_TASK0  = 3'd3;

	localparam logic        RST_POLICY = 1'b0;
	localparam logic [2:0]  RST_TASKS  = 3'd3;
	localparam logic [15:0] RST_RUNLEN = 16'd12;

	typedef logic [23:0] task_params_t;

	localparam task_params_t RST_PARAMS [SLOTS] = '{
		24'd197378, 24'd263172, 24'd394755, 24'd0
	};

	// packed from the top bit down; tick_time lands in the low bits
	typedef struct packed {
		logic [15:0] waiting;
		logic [15:0] turnaround;
		logic [15:0] completion_time;
		logic        job_done;
		logic [1:0]  running_task;
		logic        busy_res;
		logic [15:0] tick_time;
	} result_t;

	localparam int RES_W   = $bits(result_t);
	localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

/* hdl/ptts_pick.sv */
module ptts_pick #(
	parameter int N     = 4,
	parameter int IDX_W = 2
) (
	input  logic [N-1:0]  cand,
	input  logic [16:0]   key [N],
	output logic          found,
	output logic [IDX_W-1:0] pick
);

	logic [16:0] best;

	// lowest index wins on ties: strict less-than only
	always_comb begin
		found = 1'b0;
		best  = '0;
		pick  = '0;
		for (int k = 0; k < N; k++) begin
			if (cand[k] && (!found || key[k] < best)) begin
				found = 1'b1;
				best  = key[k];
				pick  = IDX_W'(k);
			end
		end
	end

endmodule

/* hdl/periodic_task_tick_scheduler.sv */
// Periodic task tick scheduler, EDF or rate monotonic.
// Result: each result beat is registered and appears in the cycle after its accepted input beat.
// Throughput: one tick per cycle; the output register holds a result while
// the next tick is accepted as long as m_tready takes the held beat.
// Reset: arst_n clears time, work and release times, loads default registers
// and sets each absolute deadline to the default relative deadline.
module periodic_task_tick_scheduler #(
	parameter int MAX_TASKS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] restart
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [ptts_pkg::TDATA_W-1:0] m_tdata,
	// [15:0] tick_time, [16] busy_res, [18:17] running_task, [19] job_done,
	// [35:20] completion_time, [51:36] turnaround, [67:52] waiting
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [23:0] cfg_wdata
);

	localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam logic [2:0] MAX_N = 3'(MAX_TASKS);

	logic        policy_q;
	logic [2:0]  tasks_q;
	logic [15:0] run_len_q;
	ptts_pkg::task_params_t tp_q [MAX_TASKS];

	logic [15:0] time_q;
	logic [7:0]  wl_q [MAX_TASKS];
	logic [16:0] nr_q [MAX_TASKS];
	logic [16:0] dl_q [MAX_TASKS];

	ptts_pkg::result_t res_q, res_d;
	logic        valid_q;

	logic        accept, restart, in_run;
	logic [2:0]  n_act;
	logic [15:0] t_eff, t_next;
	logic [MAX_TASKS-1:0] active, cand;
	logic [7:0]  wl_r [MAX_TASKS];
	logic [7:0]  wl_n [MAX_TASKS];
	logic [16:0] nr_r [MAX_TASKS];
	logic [16:0] dl_r [MAX_TASKS];
	logic [16:0] key  [MAX_TASKS];
	logic        found;
	logic [IDX_W-1:0] pick;
	logic [16:0] rel_time;
	logic [15:0] ct, tat;

	assign s_tready = !valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign restart  = s_tdata[0];
	assign m_tvalid = valid_q;
	assign m_tdata  = ptts_pkg::TDATA_W'(res_q);

	assign n_act  = (tasks_q > MAX_N) ? MAX_N : tasks_q;
	assign t_eff  = restart ? 16'd0 : time_q;
	assign in_run = t_eff < run_len_q;

	always_comb begin
		logic [7:0]  wl_e;
		logic [16:0] nr_e, dl_e;
		logic        rel;
		for (int k = 0; k < MAX_TASKS; k++) begin
			active[k] = 3'(k) < n_act;
			wl_e = restart ? 8'd0 : wl_q[k];
			nr_e = restart ? 17'd0 : nr_q[k];
			dl_e = restart ? 17'(tp_q[k][23:16]) : dl_q[k];
			rel  = active[k] && in_run && (nr_e == {1'b0, t_eff});
			wl_r[k] = rel ? tp_q[k][7:0] : wl_e;
			dl_r[k] = rel ? ({1'b0, t_eff} + 17'(tp_q[k][23:16])) : dl_e;
			nr_r[k] = rel ? (nr_e + 17'(tp_q[k][15:8])) : nr_e;
			cand[k] = active[k] && in_run && (wl_r[k] != 8'd0);
			key[k]  = policy_q ? 17'(tp_q[k][15:8]) : dl_r[k];
		end
	end

	ptts_pick #(
		.N     (MAX_TASKS),
		.IDX_W (IDX_W)
	) u_pick (
		.cand  (cand),
		.key   (key),
		.found (found),
		.pick  (pick)
	);

	always_comb begin
		for (int k = 0; k < MAX_TASKS; k++) begin
			wl_n[k] = (found && pick == IDX_W'(k)) ? wl_r[k] - 8'd1 : wl_r[k];
		end
		ct       = t_eff + 16'd1;
		rel_time = nr_r[pick] - 17'(tp_q[pick][15:8]);
		tat      = ct - rel_time[15:0];
		t_next   = in_run ? ct : t_eff;

		res_d = '0;
		res_d.tick_time = t_eff;
		if (found) begin
			res_d.busy_res     = 1'b1;
			res_d.running_task = 2'(pick);
			if (wl_r[pick] == 8'd1) begin
				res_d.job_done        = 1'b1;
				res_d.completion_time = ct;
				res_d.turnaround      = tat;
				res_d.waiting         = tat - 16'(tp_q[pick][7:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q  <= ptts_pkg::RST_POLICY;
			tasks_q   <= ptts_pkg::RST_TASKS;
			run_len_q <= ptts_pkg::RST_RUNLEN;
			for (int k = 0; k < MAX_TASKS; k++) begin
				tp_q[k] <= ptts_pkg::RST_PARAMS[k];
			end
		end else if (cfg_we) begin
			if (cfg_addr == ptts_pkg::REG_POLICY) policy_q <= cfg_wdata[0];
			if (cfg_addr == ptts_pkg::REG_TASKS) tasks_q <= cfg_wdata[2:0];
			if (cfg_addr == ptts_pkg::REG_RUNLEN) run_len_q <= cfg_wdata[15:0];
			for (int k = 0; k < MAX_TASKS; k++) begin
				if (cfg_addr == ptts_pkg::REG_TASK0 + 3'(k)) tp_q[k] <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q  <= '0;
			valid_q <= 1'b0;
			for (int k = 0; k < MAX_TASKS; k++) begin
				wl_q[k] <= '0;
				nr_q[k] <= '0;
				dl_q[k] <= 17'(ptts_pkg::RST_PARAMS[k][23:16]);
			end
		end else begin
			if (accept) begin
				valid_q <= 1'b1;
				time_q  <= t_next;
				for (int k = 0; k < MAX_TASKS; k++) begin
					wl_q[k] <= wl_n[k];
					nr_q[k] <= nr_r[k];
					dl_q[k] <= dl_r[k];
				end
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && res_q.job_done |-> res_q.busy_res)
		else $error("job_done without busy");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !res_q.busy_res |-> res_q.running_task == 2'd0
			&& res_q.completion_time == 16'd0)
		else $error("idle result not cleared");

	a_time_adv: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !restart && in_run |=> time_q == $past(time_q) + 16'd1)
		else $error("time did not advance");

	a_ct: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && res_q.job_done |-> res_q.completion_time == res_q.tick_time + 16'd1)
		else $error("completion time mismatch");

endmodule
